>>> hw/rtl/swm_pkg.sv
// Shared types and constants for the sliding window median core.
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

  localparam int SAMPLE_PORT_W = 32;
  localparam int MEDIAN_W      = 33;
  localparam int CFG_W         = 7;

  typedef struct packed {
    logic load;
    logic decide;
    logic evict;
    logic rem_step;
    logic ins_start;
    logic ins_step;
    logic med_rd0;
    logic med_rd1;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic rem_last;
    logic ins_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/swm_datapath.sv
// Datapath: window stores, removal and insertion passes, median output register.
`timescale 1ns / 1ps
`default_nettype none

module swm_datapath #(
  parameter int WINDOW_MAX   = 64,
  parameter int SAMPLE_WIDTH = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic [swm_pkg::SAMPLE_PORT_W-1:0]  sample,
  input  wire logic                               restart,
  input  wire logic                               cfg_we,
  input  wire logic [swm_pkg::CFG_W-1:0]          cfg_wdata,
  input  wire swm_pkg::cmd_t                      cmd,
  output swm_pkg::sts_t                           sts,
  output logic [swm_pkg::MEDIAN_W-1:0]            median_x2,
  output logic                                    out_valid,
  input  wire logic                               out_ready
);

  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CW = $clog2(WINDOW_MAX + 1);
  localparam int SW = SAMPLE_WIDTH;

  logic [CW-1:0]        k;
  logic [CW-1:0]        fill;
  logic [CW-1:0]        ptr;
  logic [CW-1:0]        ip;
  logic [AW-1:0]        oldest;
  logic [AW-1:0]        qa;
  logic                 found;
  logic signed [SW-1:0] s_val;
  logic signed [SW-1:0] evicted;
  logic signed [SW-1:0] ring_q;
  logic signed [SW-1:0] srt_q;
  logic signed [SW-1:0] m0;

  logic signed [SW-1:0] ring_mem [WINDOW_MAX];
  logic signed [SW-1:0] srt_mem  [WINDOW_MAX];

  logic                 full;
  logic                 rem_last;
  logic                 ins_gt;
  logic                 ins_done;
  logic                 out_free;
  logic [CW-1:0]        fill_m1;
  logic [CW-1:0]        ip_m1;
  logic [CW-1:0]        ip_m2;
  logic [CW-1:0]        oldest_inc;
  logic [CW-1:0]        k_cfg;
  logic [CW-1:0]        med_a0;
  logic [CW-1:0]        med_a1;
  logic                 match;
  logic [swm_pkg::MEDIAN_W-1:0] sum;

  logic                 srt_we;
  logic [AW-1:0]        srt_wa;
  logic signed [SW-1:0] srt_wd;
  logic                 srt_re;
  logic [AW-1:0]        srt_ra;

  assign full       = (fill == k);
  assign fill_m1    = fill - CW'(1);
  assign ip_m1      = ip - CW'(1);
  assign ip_m2      = ip - CW'(2);
  assign rem_last   = (CW'(qa) == fill_m1);
  assign ins_gt     = (srt_q > s_val);
  assign ins_done   = (ip == '0) || !ins_gt;
  assign out_free   = !out_valid || out_ready;
  assign oldest_inc = CW'(oldest) + CW'(1);
  assign med_a0     = (k - CW'(1)) >> 1;
  assign med_a1     = k >> 1;
  assign match      = (srt_q == evicted);
  assign sum        = swm_pkg::MEDIAN_W'(m0) + swm_pkg::MEDIAN_W'(srt_q);

  always_comb begin
    if (cfg_wdata == '0) begin
      k_cfg = CW'(1);
    end else if (32'(cfg_wdata) > 32'(WINDOW_MAX)) begin
      k_cfg = CW'(WINDOW_MAX);
    end else begin
      k_cfg = CW'(cfg_wdata);
    end
  end

  always_comb begin
    sts.full     = full;
    sts.rem_last = rem_last;
    sts.ins_done = ins_done;
    sts.out_free = out_free;
  end

  // sorted store port control: one write and one read per cycle
  always_comb begin
    srt_we = 1'b0;
    srt_wa = '0;
    srt_wd = s_val;
    srt_re = 1'b0;
    srt_ra = '0;
    if (cmd.ins_start && fill != '0) begin
      srt_re = 1'b1;
      srt_ra = fill_m1[AW-1:0];
    end
    if (cmd.evict) begin
      srt_re = 1'b1;
      srt_ra = '0;
    end
    if (cmd.rem_step) begin
      if (found) begin
        srt_we = 1'b1;
        srt_wa = qa - AW'(1);
        srt_wd = srt_q;
      end
      if (ptr < fill) begin
        srt_re = 1'b1;
        srt_ra = ptr[AW-1:0];
      end
    end
    if (cmd.ins_step) begin
      if (ip == '0) begin
        srt_we = 1'b1;
        srt_wa = '0;
        srt_wd = s_val;
      end else if (ins_gt) begin
        srt_we = 1'b1;
        srt_wa = ip[AW-1:0];
        srt_wd = srt_q;
        if (ip_m1 != '0) begin
          srt_re = 1'b1;
          srt_ra = ip_m2[AW-1:0];
        end
      end else begin
        srt_we = 1'b1;
        srt_wa = ip[AW-1:0];
        srt_wd = s_val;
      end
    end
    if (cmd.med_rd0) begin
      srt_re = 1'b1;
      srt_ra = med_a0[AW-1:0];
    end
    if (cmd.med_rd1) begin
      srt_re = 1'b1;
      srt_ra = med_a1[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (srt_we) begin
      srt_mem[srt_wa] <= srt_wd;
    end
    if (srt_re) begin
      srt_q <= srt_mem[srt_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      if (full) begin
        ring_q <= ring_mem[oldest];
      end else begin
        ring_mem[fill[AW-1:0]] <= s_val;
      end
    end
    if (cmd.evict) begin
      ring_mem[oldest] <= s_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k         <= CW'(1);
      fill      <= '0;
      oldest    <= '0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        k      <= k_cfg;
        fill   <= '0;
        oldest <= '0;
      end
      if (cmd.load && restart) begin
        fill   <= '0;
        oldest <= '0;
      end
      if (cmd.decide && !full) begin
        oldest <= '0;
      end
      if (cmd.evict) begin
        oldest <= (oldest_inc >= k) ? '0 : oldest_inc[AW-1:0];
        found  <= 1'b0;
      end
      if (cmd.rem_step) begin
        if (!found && match) begin
          found <= 1'b1;
        end
        if (rem_last) begin
          fill <= fill_m1;
        end
      end
      if (cmd.ins_step && ins_done) begin
        fill <= fill + CW'(1);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      s_val <= sample[SW-1:0];
    end
    if (cmd.evict) begin
      evicted <= ring_q;
      qa      <= '0;
      ptr     <= CW'(1);
    end
    if (cmd.rem_step && ptr < fill) begin
      qa  <= ptr[AW-1:0];
      ptr <= ptr + CW'(1);
    end
    if (cmd.ins_start) begin
      ip <= fill;
    end
    if (cmd.ins_step && ip != '0 && ins_gt) begin
      ip <= ip_m1;
    end
    if (cmd.med_rd1) begin
      m0 <= srt_q;
    end
    if (cmd.out_load) begin
      median_x2 <= sum;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= k)
    else $error("fill count above window size");

  a_oldest_bound: assert property (@(posedge clk) disable iff (rst) CW'(oldest) < k)
    else $error("oldest slot outside window");

  a_evict_found: assert property (@(posedge clk) disable iff (rst)
    (cmd.rem_step && rem_last) |-> (found || match))
    else $error("evicted sample missing from sorted store");

endmodule

`default_nettype wire

>>> hw/rtl/swm_ctrl.sv
// Controller: sequences load, eviction, removal, insertion and median read.
`timescale 1ns / 1ps
`default_nettype none

module swm_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  output swm_pkg::cmd_t       cmd,
  input  wire swm_pkg::sts_t  sts
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECIDE   = 4'd1;
  localparam logic [3:0] S_EVICT    = 4'd2;
  localparam logic [3:0] S_REM      = 4'd3;
  localparam logic [3:0] S_INSSTART = 4'd4;
  localparam logic [3:0] S_INS      = 4'd5;
  localparam logic [3:0] S_MED0     = 4'd6;
  localparam logic [3:0] S_MED1     = 4'd7;
  localparam logic [3:0] S_MED2     = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (sts.full) begin
          state_next = S_EVICT;
        end else begin
          cmd.ins_start = 1'b1;
          state_next    = S_INS;
        end
      end
      S_EVICT: begin
        cmd.evict  = 1'b1;
        state_next = S_REM;
      end
      S_REM: begin
        cmd.rem_step = 1'b1;
        if (sts.rem_last) begin
          state_next = S_INSSTART;
        end
      end
      S_INSSTART: begin
        cmd.ins_start = 1'b1;
        state_next    = S_INS;
      end
      S_INS: begin
        cmd.ins_step = 1'b1;
        if (sts.ins_done) begin
          state_next = S_MED0;
        end
      end
      S_MED0: begin
        if (sts.full) begin
          cmd.med_rd0 = 1'b1;
          state_next  = S_MED1;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_MED1: begin
        cmd.med_rd1 = 1'b1;
        state_next  = S_MED2;
      end
      S_MED2: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is in flight");

endmodule

`default_nettype wire

>>> hw/rtl/sliding_window_median_core.sv
// Top level of the sliding window median core.
//
//   channel  signals                          direction  beat
//   input    in_valid/in_ready, sample,       in         one sample
//            restart
//   output   out_valid/out_ready, median_x2   out        twice the window median
//   config   cfg_we, cfg_wdata                in         window size, no wait
//
// An item takes longest when the window is full (K = window size): the sorted
// store has one read and one write port, so removing the evicted sample and
// inserting the new one are each a pass over up to K entries. Reset (rst,
// synchronous) empties the window and sets the size to 1; the stores need no
// clearing. A stalled output only holds the final step; the next beat is taken
// as soon as the result is registered.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_median_core #(
  parameter int WINDOW_MAX   = 64,
  parameter int SAMPLE_WIDTH = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [swm_pkg::SAMPLE_PORT_W-1:0]  sample,
  input  wire logic                               restart,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [swm_pkg::MEDIAN_W-1:0]            median_x2,
  input  wire logic                               cfg_we,
  input  wire logic [swm_pkg::CFG_W-1:0]          cfg_wdata
);

  swm_pkg::cmd_t cmd;
  swm_pkg::sts_t sts;

  swm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  swm_datapath #(
    .WINDOW_MAX   (WINDOW_MAX),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample),
    .restart   (restart),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .median_x2 (median_x2),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

endmodule

`default_nettype wire

>>> bench/sliding_window_median_core_test.sv
// Self-checking bench for the sliding window median core: directed table, then random phases.
`timescale 1ns / 1ps

module sliding_window_median_core_test;

  localparam int WIN_MAX     = 64;
  localparam int RAND_ITEMS  = 625;
  localparam int SETTLE_CYC  = 2 * WIN_MAX + 32;
  localparam int N_ROWS      = 23;

  typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_VALUE} due_e;

  typedef struct packed {
    logic                           wr;
    logic [swm_pkg::CFG_W-1:0]      size;
    logic [31:0]                    smp;
    logic                           rs;
    due_e                           due;
    logic [swm_pkg::MEDIAN_W-1:0]   val;
  } row_t;

  logic                               clk;
  logic                               rst = 1'b1;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic [swm_pkg::SAMPLE_PORT_W-1:0]  sample = '0;
  logic                               restart = 1'b0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic [swm_pkg::MEDIAN_W-1:0]       median_x2;
  logic                               cfg_we = 1'b0;
  logic [swm_pkg::CFG_W-1:0]          cfg_wdata = '0;

  // predictor state
  logic [swm_pkg::CFG_W-1:0]          size_reg = 7'd1;
  logic signed [31:0]                 window_q [$];
  logic signed [32:0]                 median_due [$];
  due_e                               row_due = EXP_MODEL;
  logic [swm_pkg::MEDIAN_W-1:0]       row_val = '0;
  bit                                 steady = 1'b0;
  int                                 fails = 0;

  // window size 0 acts as 1, sizes above 64 saturate
  row_t rows [0:N_ROWS-1] = '{
    '{1'b0, 7'd0,   32'h8000_0000, 1'b0, EXP_VALUE, 33'h1_0000_0000},
    '{1'b0, 7'd0,   32'h7FFF_FFFF, 1'b0, EXP_VALUE, 33'h0_FFFF_FFFE},
    '{1'b0, 7'd0,   32'h0000_0000, 1'b1, EXP_VALUE, 33'h0_0000_0000},
    '{1'b0, 7'd0,   32'hFFFF_FFFF, 1'b0, EXP_VALUE, 33'h1_FFFF_FFFE},
    '{1'b1, 7'd0,   32'h0000_0005, 1'b0, EXP_VALUE, 33'd10},
    '{1'b1, 7'd2,   32'h0000_0007, 1'b0, EXP_NONE,  33'd0},
    '{1'b0, 7'd0,   32'h8000_0000, 1'b0, EXP_MODEL, 33'd0},
    '{1'b0, 7'd0,   32'h7FFF_FFFF, 1'b0, EXP_MODEL, 33'd0},
    '{1'b0, 7'd0,   32'h7FFF_FFFF, 1'b0, EXP_VALUE, 33'h0_FFFF_FFFE},
    '{1'b0, 7'd0,   32'h0000_0009, 1'b1, EXP_NONE,  33'd0},
    '{1'b0, 7'd0,   32'hFFFF_FFFD, 1'b0, EXP_MODEL, 33'd0},
    '{1'b1, 7'd3,   32'h0000_0004, 1'b0, EXP_NONE,  33'd0},
    '{1'b0, 7'd0,   32'h0000_0004, 1'b0, EXP_NONE,  33'd0},
    '{1'b0, 7'd0,   32'h0000_0004, 1'b0, EXP_VALUE, 33'd8},
    '{1'b0, 7'd0,   32'hFFFF_FFFA, 1'b0, EXP_MODEL, 33'd0},
    '{1'b0, 7'd0,   32'h0000_000B, 1'b0, EXP_MODEL, 33'd0},
    '{1'b0, 7'd0,   32'h0000_0004, 1'b0, EXP_MODEL, 33'd0},
    '{1'b1, 7'd127, 32'h1234_5678, 1'b0, EXP_NONE,  33'd0},
    '{1'b1, 7'd4,   32'h0000_0001, 1'b0, EXP_NONE,  33'd0},
    '{1'b0, 7'd0,   32'h8000_0000, 1'b0, EXP_NONE,  33'd0},
    '{1'b0, 7'd0,   32'h7FFF_FFFF, 1'b0, EXP_NONE,  33'd0},
    '{1'b0, 7'd0,   32'h8000_0000, 1'b0, EXP_MODEL, 33'd0},
    '{1'b0, 7'd0,   32'h0000_0002, 1'b0, EXP_MODEL, 33'd0}
  };

  sliding_window_median_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample    (sample),
    .restart   (restart),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .median_x2 (median_x2),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int eff_len(input logic [swm_pkg::CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > WIN_MAX) return WIN_MAX;
    return int'(v);
  endfunction

  // slides the window by one sample; returns 1 with twice the median once full
  function automatic bit slide_window(input logic signed [31:0] s, input logic rs,
                                      output logic signed [32:0] med);
    int k;
    int j;
    logic signed [31:0] ord [$];
    logic signed [31:0] t;
    k = eff_len(size_reg);
    med = '0;
    if (rs) window_q.delete();
    if (window_q.size() >= k) void'(window_q.pop_front());
    window_q.insert(window_q.size(), s);
    if (window_q.size() != k) return 1'b0;
    ord = window_q;
    for (int i = 1; i < k; i++) begin
      t = ord[i];
      j = i;
      while (j > 0 && ord[j-1] > t) begin
        ord[j] = ord[j-1];
        j--;
      end
      ord[j] = t;
    end
    med = ord[(k-1)/2] + ord[k/2];
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [31:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom;
    if (r < 8) return 32'($signed($urandom_range(0, 14)) - 7);
    if (r == 8) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 3)
                                : 32'h7FFF_FFFF - $urandom_range(0, 3);
  endfunction

  always @(posedge clk) begin : scoreboard
    logic signed [32:0] med;
    logic signed [32:0] want;
    if (rst) begin
      size_reg = 7'd1;
      window_q.delete();
    end else begin
      if (cfg_we) begin
        size_reg = cfg_wdata;
        window_q.delete();
      end
      if (in_valid && in_ready) begin
        if (slide_window(sample, restart, med) && row_due == EXP_MODEL)
          median_due.insert(median_due.size(), med);
        if (row_due == EXP_VALUE) median_due.insert(median_due.size(), row_val);
      end
      if (out_valid && out_ready) begin
        if (median_due.size() == 0) begin
          $error("median_x2: unexpected beat, got %0d", $signed(median_x2));
          fails++;
        end else begin
          want = median_due.pop_front();
          if (median_x2 !== want) begin
            $error("median_x2: expected %0d, got %0d", want, $signed(median_x2));
            fails++;
          end
        end
      end
    end
  end

  initial begin : rx_pace
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
        hold = pick_gap();
      end
    end
  end

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic push_sample(input logic [31:0] s, input logic rs, input due_e d,
                             input logic [swm_pkg::MEDIAN_W-1:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    restart  <= rs;
    row_due  = d;
    row_val  = v;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // block may still be busy on a beat with no result, so wait out the worst latency
  task automatic settle();
    in_valid <= 1'b0;
    while (median_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_size(input logic [swm_pkg::CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stim
    int total;
    int ph;
    int n;
    int eff;
    logic [swm_pkg::CFG_W-1:0] k;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_ROWS; i++) begin
      if (rows[i].wr) begin
        settle();
        write_size(rows[i].size);
      end
      push_sample(rows[i].smp, rows[i].rs, rows[i].due, rows[i].val);
    end

    total = 0;
    ph = 0;
    while (total < RAND_ITEMS) begin
      settle();
      if (ph == 1) k = 7'd64;
      else if (ph == 2) k = 7'd0;
      else if (ph == 4) k = swm_pkg::CFG_W'($urandom_range(65, 127));
      else if ($urandom_range(0, 4) == 0) k = swm_pkg::CFG_W'($urandom_range(9, 20));
      else k = swm_pkg::CFG_W'($urandom_range(1, 8));
      write_size(k);
      steady = ($urandom_range(0, 3) == 0);
      eff = eff_len(k);
      if (eff >= WIN_MAX) n = eff + $urandom_range(8, 24);
      else n = $urandom_range(eff + 4, 3 * eff + 24);
      for (int i = 0; i < n; i++)
        push_sample(pick_sample(), $urandom_range(0, 29) == 0, EXP_MODEL, '0);
      total += n;
      ph++;
    end

    settle();
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/swm_pkg.sv
hw/rtl/swm_datapath.sv
hw/rtl/swm_ctrl.sv
hw/rtl/sliding_window_median_core.sv
bench/sliding_window_median_core_test.sv
